### hw/rtl/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

  // Widths fixed by the stream fields.
  localparam int VALUE_W    = 32;
  localparam int OUT_LEN_W  = 11;
  localparam int OUT_DATA_W = 16;

  // Flipping the sign bit maps signed order onto unsigned order.
  localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

### hw/rtl/lis_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/longest_increasing_subsequence_length.sv
`timescale 1ns / 1ps

// Longest strictly increasing subsequence length, patience method. Each
// 32-bit signed value on the input stream is looked up by binary search in a
// sorted RAM of the smallest tail of every increasing run length seen so far:
// the first tail not below the value is overwritten, or the value is appended
// and the length grows. Every input transfer yields exactly one output
// transfer carrying the length after that value, a copy of tlast, and an
// overflow flag that is set once an append was dropped because the table
// already held MAX_LEN tails (the length then stays at MAX_LEN). A transfer
// with tlast high ends the sequence: after its result the length and the
// overflow flag return to zero. The block handles one value at a time. The
// search for a value takes P probes, where P is at most
// ceil(log2(MAX_LEN + 1)) (11 for the default depth of 1024); a value that
// meets an empty table needs no probe. The search does one tail compare per
// cycle against the single read port of the tail RAM. A finished result waits
// for the output register to be free, and such a stall holds off the next
// value. The output register lets a new value be accepted while the previous
// result still waits; the length output shows the low 11 bits of the length.
module longest_increasing_subsequence_length #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. tdata: value [31:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // Output stream. tdata: lis_length [10:0], zero padding [15:11].
  // tlast: final_res. tuser: overflow.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state;
  logic [LEN_W-1:0]             length;
  logic                         ovf;
  logic [lis_pkg::VALUE_W-1:0]  key;
  logic                         last_r;
  logic [LEN_W-1:0]             lo;
  logic [LEN_W-1:0]             hi;
  logic [LEN_W-1:0]             mid;

  logic                         out_valid;
  logic [lis_pkg::OUT_LEN_W-1:0] out_len;
  logic                         out_last;
  logic                         out_ovf;

  logic [lis_pkg::VALUE_W-1:0]  rdata;
  logic [ADDR_W-1:0]            raddr;
  logic                         we;

  logic                         in_fire;
  logic                         out_free;
  logic                         out_load;
  logic                         tail_lt;
  logic [LEN_W-1:0]             lo_next;
  logic [LEN_W-1:0]             hi_next;
  logic [LEN_W-1:0]             mid_next;
  logic [LEN_W-1:0]             half_len;
  logic                         append;
  logic                         can_grow;
  logic [LEN_W-1:0]             length_next;
  logic                         ovf_next;
  logic [LEN_W+lis_pkg::OUT_LEN_W-1:0] len_ext;

  // The input is held off during reset so that no transfer is taken and lost.
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = (state == ST_DONE) && out_free;

  // One search step: compare the probed tail, narrow the window and pick the
  // next probe in the same cycle so the RAM sees a new address every cycle.
  assign tail_lt  = rdata < key;
  assign lo_next  = tail_lt ? mid + LEN_W'(1) : lo;
  assign hi_next  = tail_lt ? hi : mid;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
  assign half_len = length >> 1;
  assign raddr    = (state == ST_CMP) ? mid_next[ADDR_W-1:0] : half_len[ADDR_W-1:0];

  // When the search ends, lo is the insert position. It equals the length
  // when every tail is below the key, which means an append.
  assign append      = (lo == length);
  assign can_grow    = (length < MAX_LEN_L);
  assign we          = out_load && (!append || can_grow);
  assign length_next = (append && can_grow) ? length + LEN_W'(1) : length;
  assign ovf_next    = ovf || (append && !can_grow);
  assign len_ext     = {{lis_pkg::OUT_LEN_W{1'b0}}, length_next};

  lis_ram #(
    .WIDTH (lis_pkg::VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_tails (
    .clk   (clk),
    .we    (we),
    .waddr (lo[ADDR_W-1:0]),
    .wdata (key),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= '0;
      ovf    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (length != '0) ? ST_CMP : ST_DONE;
          end
        end
        ST_CMP: begin
          if (!(lo_next < hi_next)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (last_r) begin
              length <= '0;
              ovf    <= 1'b0;
            end else begin
              length <= length_next;
              ovf    <= ovf_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Search window and the item being worked on.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key    <= s_axis_tdata ^ lis_pkg::SIGN_FLIP;
      last_r <= s_axis_tlast;
      lo     <= '0;
      hi     <= length;
      mid    <= half_len;
    end else if (state == ST_CMP) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_len  <= len_ext[lis_pkg::OUT_LEN_W-1:0];
      out_last <= last_r;
      out_ovf  <= ovf_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(lis_pkg::OUT_DATA_W - lis_pkg::OUT_LEN_W){1'b0}}, out_len};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;

  // The table never holds more tails than the RAM has entries.
  assert property (@(posedge clk) disable iff (rst) length <= MAX_LEN_L)
    else $error("table length above MAX_LEN");

  // A probe is only outstanding while the search window is not empty.
  assert property (@(posedge clk) disable iff (rst) (state == ST_CMP) |-> (lo < hi))
    else $error("search probe with empty window");

  // When the search ends, the insert position never lies beyond the current table.
  assert property (@(posedge clk) disable iff (rst) (state == ST_DONE) |-> (lo <= length))
    else $error("insert position beyond table length");

  // A result for the end of a sequence leaves an empty table behind.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && last_r) |=> (length == '0 && !ovf))
    else $error("sequence state not cleared after last transfer");

endmodule

### sim/tb_longest_increasing_subsequence_length.sv
`timescale 1ns / 1ps

// Stream-level check of the LIS length block. Every value accepted on the input
// stream is run through a local patience-table model, which queues the length,
// end-of-sequence and overflow flags that the block must return. Results leave
// the block in order, so each output transfer is compared with the oldest queued
// entry. Directed runs cover the value extremes, duplicates, falling runs and a
// table filled past its depth. Random sequences of several shapes follow, with
// gaps on the input side, stalls on the output side and one long output hold-off.
module tb_longest_increasing_subsequence_length;

  localparam int VALUE_W    = lis_pkg::VALUE_W;
  localparam int OUT_LEN_W  = lis_pkg::OUT_LEN_W;
  localparam int OUT_DATA_W = lis_pkg::OUT_DATA_W;

  localparam int TABLE_DEPTH = 1024;        // default MAX_LEN of the block
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum int {
    SHAPE_WIDE,       // values drawn from the full range
    SHAPE_NARROW,     // small range, many repeated values
    SHAPE_RISING,     // upward drift with noise
    SHAPE_EXTREME     // values at and next to the range ends
  } seq_shape_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 fin;
    logic                 ovf;
  } lis_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  // Local copy of the patience table, in signed order.
  logic signed [VALUE_W-1:0] tails [TABLE_DEPTH];
  int                        table_len     = 0;
  logic                      overflow_seen = 1'b0;

  lis_result_t expected_results [$];

  int   error_count  = 0;
  int   cycle_count  = 0;
  bit   sender_gaps  = 1'b1;
  bit   receiver_stalls = 1'b1;
  int   hold_request = 0;       // bumped by a test to ask for a hold-off
  int   hold_served  = 0;
  int   hold_left    = 0;

  longest_increasing_subsequence_length uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Apply one accepted value to the local table and queue the result it makes.
  function automatic void predict_lis_length(logic signed [VALUE_W-1:0] value,
                                             logic fin);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t res;
    lo = 0;
    hi = table_len;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tails[mid] < value) lo = mid + 1;
      else hi = mid;
    end
    if (lo < table_len) begin
      tails[lo] = value;
    end else if (table_len < TABLE_DEPTH) begin
      tails[table_len] = value;
      table_len++;
    end else begin
      // Table is full: the append is dropped and the length saturates.
      overflow_seen = 1'b1;
    end
    res.length = OUT_LEN_W'(table_len);
    res.fin    = fin;
    res.ovf    = overflow_seen;
    expected_results.insert(expected_results.size(), res);
    if (fin) begin
      table_len     = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= 50)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
  endtask

  // Offer one value and wait for its transfer. tvalid stays high on return so
  // that back-to-back values keep the input busy.
  task automatic send_value(logic signed [VALUE_W-1:0] value, logic fin);
    if (sender_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    predict_lis_length(value, fin);
  endtask

  function automatic logic signed [VALUE_W-1:0] extreme_value();
    case ($urandom_range(6))
      0: return VAL_MIN;
      1: return VAL_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return VAL_MAX - 1;
      default: return VAL_MAX;
    endcase
  endfunction

  // Whole sequences, each closed by a transfer with tlast high.
  task automatic run_random_sequences(int item_goal);
    int         sent;
    int         seq_len;
    int         drift;
    seq_shape_t shape;
    logic signed [VALUE_W-1:0] value;
    sent = 0;
    while (sent < item_goal) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      shape   = seq_shape_t'($urandom_range(3));
      drift   = int'($urandom_range(1000)) - 500;
      for (int i = 0; i < seq_len; i++) begin
        case (shape)
          SHAPE_WIDE:    value = $urandom;
          SHAPE_NARROW:  value = int'($urandom_range(16)) - 8;
          SHAPE_RISING: begin
            drift += int'($urandom_range(3000)) - 500;
            value  = drift + int'($urandom_range(6000)) - 1000;
          end
          default:       value = extreme_value();
        endcase
        send_value(value, i == seq_len - 1);
      end
      sent += seq_len;
    end
  endtask

  task automatic test_extremes();
    // Rise across the full signed range.
    send_value(VAL_MIN, 1'b0);
    send_value(-1, 1'b0);
    send_value(0, 1'b0);
    send_value(1, 1'b0);
    send_value(VAL_MAX, 1'b1);
    // A sequence of a single value.
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b1);
    // Repeated values must not lengthen a strictly increasing run.
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(6, 1'b0);
    send_value(6, 1'b1);
    // Falling run: each falling value replaces the first tail, then two rising values grow the table.
    send_value(VAL_MAX, 1'b0);
    send_value(100, 1'b0);
    send_value(-50, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MIN + 1, 1'b0);
    send_value(0, 1'b1);
    // Replacement in the middle of the table.
    send_value(10, 1'b0);
    send_value(20, 1'b0);
    send_value(30, 1'b0);
    send_value(15, 1'b0);
    send_value(16, 1'b0);
    send_value(17, 1'b1);
  endtask

  // Fill the table, push past its depth, and show that the flag holds until
  // the sequence ends and is gone in the next one.
  task automatic test_table_full();
    longint value;
    value = longint'(VAL_MIN);
    for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
      send_value(VALUE_W'(value), 1'b0);
      value += $urandom_range(1, 1 << 21);
    end
    send_value(VAL_MIN, 1'b0);          // overwrite while saturated
    send_value(VALUE_W'(value), 1'b1);  // end on a dropped append
    send_value(0, 1'b1);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
  endtask

  // Hold the output off long enough that the block fills and stops taking input.
  task automatic test_output_hold_off();
    hold_request <= hold_request + 1;
    run_random_sequences(40);
  endtask

  task automatic test_no_idling();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_random_sequences(120);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_random_sequences();
    run_random_sequences(150);
  endtask

  // Output side: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request != hold_served) begin
      hold_served   <= hold_request;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (receiver_stalls) begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lis_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, length", m_axis_tdata, -1);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== {{(OUT_DATA_W-OUT_LEN_W){1'b0}}, want.length})
          report_mismatch("lis_length", m_axis_tdata, want.length);
        if (m_axis_tlast !== want.fin)
          report_mismatch("final_res", m_axis_tlast, want.fin);
        if (m_axis_tuser !== want.ovf)
          report_mismatch("overflow", m_axis_tuser, want.ovf);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_table_full();
    test_output_hold_off();
    test_no_idling();
    test_random_sequences();

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### longest_increasing_subsequence_length.f
hw/rtl/lis_pkg.sv
hw/rtl/lis_ram.sv
hw/rtl/longest_increasing_subsequence_length.sv
sim/tb_longest_increasing_subsequence_length.sv
